// ===== hw/rtl/tti_pkg.sv =====
`timescale 1ns / 1ps

package tti_pkg;

  localparam logic [4:0] MAX_X_POINTS = 5'd16;
  localparam logic [4:0] MAX_Y_POINTS = 5'd16;
  localparam logic [4:0] MAX_Z_POINTS = 5'd16;

  localparam logic [2:0] CMD_LOAD_X    = 3'd0;
  localparam logic [2:0] CMD_LOAD_Y    = 3'd1;
  localparam logic [2:0] CMD_LOAD_Z    = 3'd2;
  localparam logic [2:0] CMD_LOAD_GRID = 3'd3;
  localparam logic [2:0] CMD_QUERY     = 3'd4;

  localparam logic [1:0] CFG_X_POINTS = 2'd0;
  localparam logic [1:0] CFG_Y_POINTS = 2'd1;
  localparam logic [1:0] CFG_Z_POINTS = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // blend steps: four along x, two along y, one along z
  localparam logic [2:0] LERP_LAST    = 3'd6;
  localparam logic [2:0] LERP_FIRST_Y = 3'd4;
  localparam logic [2:0] LERP_FIRST_Z = 3'd6;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAP_FIRST,
    OP_CLAMP,
    OP_SCAN,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_CORNER,
    OP_MUL,
    OP_ADD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       accept;
    logic [1:0] axis;
    logic [3:0] rd_addr;
    logic       scan_check;
    logic       scan_default;
    logic [3:0] scan_cell;
    logic [2:0] corner;
    logic [2:0] cap_idx;
    logic [2:0] step;
  } ctrl_cmd_t;

  function automatic logic [4:0] eff_count(input logic [4:0] n, input logic [4:0] maxn);
    logic [4:0] r;
    r = n;
    if (n < 5'd2) r = 5'd2;
    else if (n > maxn) r = maxn;
    return r;
  endfunction

endpackage

// ===== hw/rtl/tti_ctrl.sv =====
`timescale 1ns / 1ps

module tti_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          command_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [4:0]          cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tti_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_CLAMP,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_CORNER,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] axis_q;
  logic [3:0] cnt_q;
  logic [4:0] nx_q, ny_q, nz_q;
  logic       out_valid_q;

  logic [4:0] n_sel;
  logic [4:0] n_minus1;
  logic       accept;
  logic       out_free;

  always_comb begin
    unique case (axis_q)
      tti_pkg::AXIS_X: n_sel = tti_pkg::eff_count(nx_q, tti_pkg::MAX_X_POINTS);
      tti_pkg::AXIS_Y: n_sel = tti_pkg::eff_count(ny_q, tti_pkg::MAX_Y_POINTS);
      default:         n_sel = tti_pkg::eff_count(nz_q, tti_pkg::MAX_Z_POINTS);
    endcase
  end

  assign n_minus1 = n_sel - 5'd1;
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o              = '0;
    cmd_o.op           = tti_pkg::OP_NOP;
    cmd_o.accept       = accept;
    cmd_o.axis         = axis_q;
    unique case (state_q)
      ST_IDLE:     cmd_o.op = tti_pkg::OP_NOP;
      ST_RD_FIRST: cmd_o.rd_addr = 4'd0;
      ST_RD_LAST: begin
        cmd_o.rd_addr = n_minus1[3:0];
        cmd_o.op      = tti_pkg::OP_CAP_FIRST;
      end
      ST_CLAMP: begin
        cmd_o.rd_addr = 4'd0;
        cmd_o.op      = tti_pkg::OP_CLAMP;
      end
      ST_SCAN: begin
        // the next point's read is issued in the cycle before its scan step
        cmd_o.op           = tti_pkg::OP_SCAN;
        cmd_o.rd_addr      = cnt_q + 4'd1;
        cmd_o.scan_check   = (cnt_q != 4'd0);
        cmd_o.scan_default = (cnt_q == 4'd1);
        cmd_o.scan_cell    = cnt_q - 4'd1;
      end
      ST_DIV_INIT: cmd_o.op = tti_pkg::OP_DIV_INIT;
      ST_DIV:      cmd_o.op = tti_pkg::OP_DIV_STEP;
      ST_DIV_END:  cmd_o.op = tti_pkg::OP_DIV_END;
      ST_CORNER: begin
        cmd_o.corner = cnt_q[2:0];
        if (cnt_q != 4'd0) begin
          cmd_o.op      = tti_pkg::OP_CORNER;
          cmd_o.cap_idx = cnt_q[2:0] - 3'd1;
        end
      end
      ST_MUL: begin
        cmd_o.op   = tti_pkg::OP_MUL;
        cmd_o.step = cnt_q[2:0];
      end
      ST_ADD: begin
        cmd_o.op   = tti_pkg::OP_ADD;
        cmd_o.step = cnt_q[2:0];
      end
      ST_DONE: if (out_free) cmd_o.op = tti_pkg::OP_OUT;
      default: cmd_o.op = tti_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= tti_pkg::AXIS_X;
      cnt_q       <= 4'd0;
      nx_q        <= 5'd2;
      ny_q        <= 5'd2;
      nz_q        <= 5'd2;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tti_pkg::CFG_X_POINTS: nx_q <= cfg_data_i;
          tti_pkg::CFG_Y_POINTS: ny_q <= cfg_data_i;
          tti_pkg::CFG_Z_POINTS: nz_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && command_i == tti_pkg::CMD_QUERY) begin
            axis_q  <= tti_pkg::AXIS_X;
            state_q <= ST_RD_FIRST;
          end
        end
        ST_RD_FIRST: state_q <= ST_RD_LAST;
        ST_RD_LAST:  state_q <= ST_CLAMP;
        ST_CLAMP: begin
          cnt_q   <= 4'd0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cnt_q == n_minus1[3:0]) state_q <= ST_DIV_INIT;
          else cnt_q <= cnt_q + 4'd1;
        end
        ST_DIV_INIT: begin
          cnt_q   <= 4'd0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == 4'd15) state_q <= ST_DIV_END;
          else cnt_q <= cnt_q + 4'd1;
        end
        ST_DIV_END: begin
          cnt_q <= 4'd0;
          if (axis_q == tti_pkg::AXIS_Z) begin
            state_q <= ST_CORNER;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_RD_FIRST;
          end
        end
        ST_CORNER: begin
          if (cnt_q == 4'd8) begin
            cnt_q   <= 4'd0;
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_MUL: state_q <= ST_ADD;
        ST_ADD: begin
          if (cnt_q[2:0] == tti_pkg::LERP_LAST) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/tti_dp.sv =====
`timescale 1ns / 1ps

module tti_dp (
  input  logic               clk_i,
  input  tti_pkg::ctrl_cmd_t cmd_i,
  input  logic [2:0]         command_i,
  input  logic [3:0]         index_x_i,
  input  logic [3:0]         index_y_i,
  input  logic [3:0]         index_z_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_y_i,
  input  logic signed [31:0] query_z_i,
  output logic signed [31:0] interpolated_value_o
);

  logic signed [31:0] x_axis_q [16];
  logic signed [31:0] y_axis_q [16];
  logic signed [31:0] z_axis_q [16];
  logic signed [31:0] grid_q   [4096];

  logic signed [31:0] x_rd_q, y_rd_q, z_rd_q, grid_rd_q;
  logic signed [31:0] qx_q, qy_q, qz_q;
  logic signed [31:0] first_q, prev_q, lo_q, hi_q;
  logic signed [32:0] c_q;
  logic [3:0]         found_q;
  logic [32:0]        den_q, rem_q;
  logic [15:0]        quo_q;
  logic               wzero_q, wsat_q;
  logic [15:0]        wx_q, wy_q, wz_q;
  logic [3:0]         cx_q, cy_q, cz_q;
  logic signed [31:0] v_q [8];
  logic signed [49:0] prod_q;
  logic signed [31:0] out_q;

  logic signed [31:0] axis_rd, q_sel;
  logic signed [32:0] q_ext, first_ext, rd_ext, prev_ext, clamp_c;
  logic               scan_hit;
  logic signed [33:0] diff_c;
  logic signed [32:0] den_w;
  logic [33:0]        div_t;
  logic               div_ge;
  logic [15:0]        w_end, w_sel;
  logic [3:0]         gx, gy, gz;
  logic signed [32:0] lerp_diff;
  logic signed [16:0] w_ext;
  logic signed [49:0] prod_w, biased, shifted;
  logic signed [31:0] lerp_res;
  logic [2:0]         tail;

  always_comb begin
    unique case (cmd_i.axis)
      tti_pkg::AXIS_X: begin axis_rd = x_rd_q; q_sel = qx_q; end
      tti_pkg::AXIS_Y: begin axis_rd = y_rd_q; q_sel = qy_q; end
      default:         begin axis_rd = z_rd_q; q_sel = qz_q; end
    endcase
  end

  assign q_ext     = {q_sel[31], q_sel};
  assign first_ext = {first_q[31], first_q};
  assign rd_ext    = {axis_rd[31], axis_rd};
  assign prev_ext  = {prev_q[31], prev_q};

  // clamp one LSB inside the axis ends; 33 bits so it cannot wrap
  always_comb begin
    if (q_ext <= first_ext) clamp_c = first_ext + 33'sd1;
    else if (q_ext >= rd_ext) clamp_c = rd_ext - 33'sd1;
    else clamp_c = q_ext;
  end

  assign scan_hit = (c_q >= prev_ext) && (c_q < rd_ext);

  assign diff_c = {c_q[32], c_q} - {{2{lo_q[31]}}, lo_q};
  assign den_w  = {hi_q[31], hi_q} - {lo_q[31], lo_q};
  assign div_t  = {rem_q, 1'b0};
  assign div_ge = div_t >= {1'b0, den_q};

  always_comb begin
    if (wzero_q) w_end = 16'd0;
    else if (wsat_q) w_end = 16'hFFFF;
    else w_end = quo_q;
  end

  assign gx = cx_q + {3'd0, cmd_i.corner[0]};
  assign gy = cy_q + {3'd0, cmd_i.corner[1]};
  assign gz = cz_q + {3'd0, cmd_i.corner[2]};

  always_comb begin
    if (cmd_i.step < tti_pkg::LERP_FIRST_Y) w_sel = wx_q;
    else if (cmd_i.step < tti_pkg::LERP_FIRST_Z) w_sel = wy_q;
    else w_sel = wz_q;
  end

  assign lerp_diff = {v_q[1][31], v_q[1]} - {v_q[0][31], v_q[0]};
  assign w_ext     = {1'b0, w_sel};
  assign prod_w    = lerp_diff * w_ext;
  // truncate toward zero on the divide by 65536
  assign biased    = prod_q + (prod_q[49] ? 50'sd65535 : 50'sd0);
  assign shifted   = biased >>> 16;
  assign lerp_res  = v_q[0] + shifted[31:0];
  assign tail      = tti_pkg::LERP_LAST - cmd_i.step;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      unique case (command_i)
        tti_pkg::CMD_LOAD_X:    x_axis_q[index_x_i] <= load_value_i;
        tti_pkg::CMD_LOAD_Y:    y_axis_q[index_y_i] <= load_value_i;
        tti_pkg::CMD_LOAD_Z:    z_axis_q[index_z_i] <= load_value_i;
        tti_pkg::CMD_LOAD_GRID: grid_q[{index_x_i, index_y_i, index_z_i}] <= load_value_i;
        default: ;
      endcase
    end
    x_rd_q    <= x_axis_q[cmd_i.rd_addr];
    y_rd_q    <= y_axis_q[cmd_i.rd_addr];
    z_rd_q    <= z_axis_q[cmd_i.rd_addr];
    grid_rd_q <= grid_q[{gx, gy, gz}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && command_i == tti_pkg::CMD_QUERY) begin
      qx_q <= query_x_i;
      qy_q <= query_y_i;
      qz_q <= query_z_i;
    end
    unique case (cmd_i.op)
      tti_pkg::OP_CAP_FIRST: first_q <= axis_rd;
      tti_pkg::OP_CLAMP:     c_q <= clamp_c;
      tti_pkg::OP_SCAN: begin
        prev_q <= axis_rd;
        // cell 0 is the fallback when nothing brackets
        if (cmd_i.scan_check && (cmd_i.scan_default || scan_hit)) begin
          lo_q    <= prev_q;
          hi_q    <= axis_rd;
          found_q <= cmd_i.scan_cell;
        end
      end
      tti_pkg::OP_DIV_INIT: begin
        den_q   <= den_w;
        rem_q   <= diff_c[32:0];
        quo_q   <= 16'd0;
        wzero_q <= (den_w <= 33'sd0) || (diff_c < 34'sd0);
        wsat_q  <= diff_c >= {den_w[32], den_w};
      end
      tti_pkg::OP_DIV_STEP: begin
        if (div_ge) begin
          rem_q <= 33'(div_t - {1'b0, den_q});
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= div_t[32:0];
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
      tti_pkg::OP_DIV_END: begin
        unique case (cmd_i.axis)
          tti_pkg::AXIS_X: begin wx_q <= w_end; cx_q <= found_q; end
          tti_pkg::AXIS_Y: begin wy_q <= w_end; cy_q <= found_q; end
          default:         begin wz_q <= w_end; cz_q <= found_q; end
        endcase
      end
      tti_pkg::OP_CORNER: v_q[cmd_i.cap_idx] <= grid_rd_q;
      tti_pkg::OP_MUL:    prod_q <= prod_w;
      tti_pkg::OP_ADD: begin
        // pop the head pair, push the blend at the tail of the queue
        for (int i = 0; i < 6; i++) begin
          if (i != int'(tail)) v_q[i] <= v_q[i+2];
        end
        v_q[tail] <= lerp_res;
      end
      tti_pkg::OP_OUT: out_q <= v_q[0];
      default: ;
    endcase
  end

  assign interpolated_value_o = out_q;

endmodule

// ===== hw/rtl/trilinear_table_interpolator_unit.sv =====
`timescale 1ns / 1ps

// Trilinear interpolator over a non-uniform 3-D table. Loads (commands 0..3) write an axis
// point or a grid sample in the cycle of the transfer and give no result; the block is ready
// again in the next cycle. A query (command 4) is worked on alone: for each axis the sequencer
// reads the two ends, scans all n points through the single axis read port and runs a 16-step
// restoring divider for the weight; then eight grid reads through the one grid port and seven
// blends on one multiplier. A query ends only once the output register is free to take its
// result. The output register lets the next transfer in while a result still waits.
module trilinear_table_interpolator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic [3:0]         index_x_i,
  input  logic [3:0]         index_y_i,
  input  logic [3:0]         index_z_i,
  input  logic signed [31:0] load_value_i,
  input  logic signed [31:0] query_x_i,
  input  logic signed [31:0] query_y_i,
  input  logic signed [31:0] query_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] interpolated_value_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [4:0]         cfg_data_i
);

  tti_pkg::ctrl_cmd_t cmd;

  tti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tti_dp u_dp (
    .clk_i                (clk_i),
    .cmd_i                (cmd),
    .command_i            (command_i),
    .index_x_i            (index_x_i),
    .index_y_i            (index_y_i),
    .index_z_i            (index_z_i),
    .load_value_i         (load_value_i),
    .query_x_i            (query_x_i),
    .query_y_i            (query_y_i),
    .query_z_i            (query_z_i),
    .interpolated_value_o (interpolated_value_o)
  );

endmodule

// ===== hw/rtl/tti_checker.sv =====
`timescale 1ns / 1ps

module tti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] interpolated_value_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interpolated_value_o))
    else $error("stalled result changed or dropped");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && command_i == tti_pkg::CMD_QUERY |=> in_stall_o)
    else $error("query transfer did not start work");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && command_i != tti_pkg::CMD_QUERY |=> !in_stall_o)
    else $error("load transfer blocked the input");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a query in progress");

endmodule

bind trilinear_table_interpolator_unit tti_checker u_tti_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .command_i            (command_i),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .interpolated_value_o (interpolated_value_o)
);
